/* sv/arm_mov_execute_with_shifter_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the MOV execute block
// Shared wrappers for the concurrent checks in the RTL files.
// ---------------------------------------------------------------------------
`ifndef ARM_MOV_EXECUTE_WITH_SHIFTER_MACROS_SVH
`define ARM_MOV_EXECUTE_WITH_SHIFTER_MACROS_SVH

// Condition holds at every clock edge outside reset
`define AMX_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define AMX_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define AMX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/amx_pkg.sv */
// ---------------------------------------------------------------------------
// amx_pkg
// Types and codes shared by the MOV execute pipeline stages.
// ---------------------------------------------------------------------------
package amx_pkg;

    // Instruction forms
    localparam logic [1:0] ACT_ROT_IMM = 2'd0;
    localparam logic [1:0] ACT_IMM16   = 2'd1;
    localparam logic [1:0] ACT_SHF_REG = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // Register shift kinds
    localparam logic [1:0] KIND_LSL = 2'd0;
    localparam logic [1:0] KIND_LSR = 2'd1;
    localparam logic [1:0] KIND_ASR = 2'd2;
    localparam logic [1:0] KIND_ROR = 2'd3;

    // Width of the low immediate field (rotate and imm8)
    localparam int IMM_LOW_W = 12;

    typedef logic [2:0] t_shift_op;

    // Resolved shifter operations
    localparam t_shift_op SH_PASS  = 3'd0;  // value unchanged, carry from C
    localparam t_shift_op SH_LSL   = 3'd1;
    localparam t_shift_op SH_LSR   = 3'd2;
    localparam t_shift_op SH_ASR   = 3'd3;
    localparam t_shift_op SH_ROR   = 3'd4;
    localparam t_shift_op SH_RRX   = 3'd5;
    localparam t_shift_op SH_LSR32 = 3'd6;
    localparam t_shift_op SH_ASR32 = 3'd7;

    // Decoded request for the shifter stage
    typedef struct packed {
        logic [31:0] value;
        logic [4:0]  amt;
        t_shift_op   op;
        logic        cin;
        logic        wr;
    } t_shift_req;

    // Shifter stage output
    typedef struct packed {
        logic [31:0] value;
        logic        carry;
        logic        wr;
    } t_shift_res;

endpackage

/* sv/amx_decode.sv */
// ---------------------------------------------------------------------------
// amx_decode
// Stage 1: resolves the instruction form into one shifter operation.
// ---------------------------------------------------------------------------
module amx_decode
    import amx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_action,
    input  logic [IMM_LOW_W-1:0] i_imm_low12,
    input  logic [3:0]           i_imm_high4,
    input  logic [1:0]           i_shift_kind,
    input  logic [4:0]           i_shift_imm,
    input  logic [31:0]          i_source_value,
    input  logic                 i_carry_in,
    input  logic                 i_set_flags,
    output logic                 o_valid,
    output t_shift_req           o_req
);

`include "arm_mov_execute_with_shifter_macros.svh"

    logic       r_valid;
    t_shift_req r_req;
    t_shift_req n_req;
    logic [4:0] w_rot;

    // Modified immediate: rotate right by twice the 4-bit field
    assign w_rot = {i_imm_low12[11:8], 1'b0};

    // Form decode
    always_comb begin
        n_req.value = 32'd0;
        n_req.amt   = 5'd0;
        n_req.op    = SH_PASS;
        n_req.cin   = i_carry_in;
        n_req.wr    = 1'b0;
        unique case (i_action)
            ACT_ROT_IMM: begin
                n_req.value = {24'd0, i_imm_low12[7:0]};
                n_req.amt   = w_rot;
                n_req.op    = (w_rot == 5'd0) ? SH_PASS : SH_ROR;
                n_req.wr    = i_set_flags;
            end
            ACT_IMM16: begin
                n_req.value = {16'd0, i_imm_high4, i_imm_low12};
            end
            ACT_SHF_REG: begin
                n_req.value = i_source_value;
                n_req.amt   = i_shift_imm;
                n_req.wr    = i_set_flags;
                unique case (i_shift_kind)
                    KIND_LSL: n_req.op = (i_shift_imm == 5'd0) ? SH_PASS  : SH_LSL;
                    KIND_LSR: n_req.op = (i_shift_imm == 5'd0) ? SH_LSR32 : SH_LSR;
                    KIND_ASR: n_req.op = (i_shift_imm == 5'd0) ? SH_ASR32 : SH_ASR;
                    KIND_ROR: n_req.op = (i_shift_imm == 5'd0) ? SH_RRX   : SH_ROR;
                    default:  n_req.op = SH_PASS;
                endcase
            end
            ACT_NONE: begin
                n_req.value = 32'd0;
            end
            default: begin
                n_req.value = 32'd0;
            end
        endcase
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_req <= n_req;
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

    // Sixteen-bit immediate never writes flags
    `AMX_ASSERT_NEXT(a_imm16_no_flags, i_clk, i_rst_n, i_valid && (i_action == ACT_IMM16), !r_req.wr, "imm16 request marked as writing flags")
    // A zero rotation leaves the immediate untouched
    `AMX_ASSERT_NEXT(a_rot_zero_pass, i_clk, i_rst_n, i_valid && (i_action == ACT_ROT_IMM) && (i_imm_low12[11:8] == 4'd0), r_req.op == SH_PASS, "zero rotation not decoded as pass")

endmodule

/* sv/amx_shift.sv */
// ---------------------------------------------------------------------------
// amx_shift
// Stage 2: barrel shifter with shifter carry out.
// ---------------------------------------------------------------------------
module amx_shift
    import amx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_shift_req i_req,
    output logic       o_valid,
    output t_shift_res o_res
);

`include "arm_mov_execute_with_shifter_macros.svh"

    logic        r_valid;
    t_shift_res  r_res;
    t_shift_res  n_res;
    logic [32:0] w_lsl;
    logic [32:0] w_rsh;
    logic [32:0] w_asr;
    logic [63:0] w_ror;

    // Shift datapaths; the extra bit catches the last bit shifted out
    assign w_lsl = {1'b0, i_req.value} << i_req.amt;
    assign w_rsh = {i_req.value, 1'b0} >> i_req.amt;
    assign w_asr = 33'($signed({i_req.value, 1'b0}) >>> i_req.amt);
    assign w_ror = {i_req.value, i_req.value} >> i_req.amt;

    // Operation select
    always_comb begin
        n_res.wr = i_req.wr;
        unique case (i_req.op)
            SH_PASS: begin
                n_res.value = i_req.value;
                n_res.carry = i_req.cin;
            end
            SH_LSL: begin
                n_res.value = w_lsl[31:0];
                n_res.carry = w_lsl[32];
            end
            SH_LSR: begin
                n_res.value = w_rsh[32:1];
                n_res.carry = w_rsh[0];
            end
            SH_ASR: begin
                n_res.value = w_asr[32:1];
                n_res.carry = w_asr[0];
            end
            SH_ROR: begin
                n_res.value = w_ror[31:0];
                n_res.carry = w_ror[31];
            end
            SH_RRX: begin
                n_res.value = {i_req.cin, i_req.value[31:1]};
                n_res.carry = i_req.value[0];
            end
            SH_LSR32: begin
                n_res.value = 32'd0;
                n_res.carry = i_req.value[31];
            end
            SH_ASR32: begin
                n_res.value = {32{i_req.value[31]}};
                n_res.carry = i_req.value[31];
            end
            default: begin
                n_res.value = i_req.value;
                n_res.carry = i_req.cin;
            end
        endcase
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    // Pass-through keeps value and incoming carry
    `AMX_ASSERT_NEXT(a_pass_keeps, i_clk, i_rst_n, i_valid && (i_req.op == SH_PASS), (r_res.value == $past(i_req.value)) && (r_res.carry == $past(i_req.cin)), "pass operation altered value or carry")
    // Rotate carry is the new top bit
    `AMX_ASSERT_NEXT(a_ror_carry, i_clk, i_rst_n, i_valid && (i_req.op == SH_ROR), r_res.carry == r_res.value[31], "rotate carry differs from bit 31")

endmodule

/* sv/arm_mov_execute_with_shifter.sv */
// ---------------------------------------------------------------------------
// arm_mov_execute_with_shifter
// MOV execute unit: immediate forms and shifted register, with N, Z, C.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel: drive the instruction fields with start high; the
//   request is taken at a clock edge where start is high and busy is low.
//   busy is high during reset and until the next clock edge after it, then stays
//   low, so one request can be issued every cycle.
//   Result channel: o_valid is high for exactly one cycle with the result
//   fields; the receiver must take it then, there is no back-pressure.
//   Path: a request taken at a clock edge is registered in turn by the three
//   register stages decode, barrel shifter and flags; the last drives the outputs.
//   Throughput: one request per cycle once busy is low; results leave in
//   request order.
//   Reset (i_rst_n low, synchronous) empties the pipeline; requests in
//   flight are dropped and no result is produced for them.
//   Flags N, Z and C are always computed; they apply only when
//   o_flags_written is high. V is not handled here.
// ---------------------------------------------------------------------------
module arm_mov_execute_with_shifter
    import amx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_action,
    input  logic [IMM_LOW_W-1:0] i_imm_low12,
    input  logic [3:0]           i_imm_high4,
    input  logic [1:0]           i_shift_kind,
    input  logic [4:0]           i_shift_imm,
    input  logic [31:0]          i_source_value,
    input  logic                 i_carry_in,
    input  logic                 i_set_flags,
    output logic                 o_valid,
    output logic [31:0]          o_result_value,
    output logic                 o_flags_written,
    output logic                 o_neg_flag,
    output logic                 o_zero_flag,
    output logic                 o_carry_out
);

`include "arm_mov_execute_with_shifter_macros.svh"

    logic        r_busy;
    logic        w_accept;
    logic        w_dec_valid;
    t_shift_req  w_dec_req;
    logic        w_shf_valid;
    t_shift_res  w_shf_res;

    logic        r_valid;
    logic [31:0] r_result;
    logic        r_wr;
    logic        r_neg;
    logic        r_zero;
    logic        r_carry;

    // Busy register: set during reset, cleared once reset is released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    // Stage 1: decode
    amx_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_accept),
        .i_action       (i_action),
        .i_imm_low12    (i_imm_low12),
        .i_imm_high4    (i_imm_high4),
        .i_shift_kind   (i_shift_kind),
        .i_shift_imm    (i_shift_imm),
        .i_source_value (i_source_value),
        .i_carry_in     (i_carry_in),
        .i_set_flags    (i_set_flags),
        .o_valid        (w_dec_valid),
        .o_req          (w_dec_req)
    );

    // Stage 2: barrel shifter
    amx_shift u_shift (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_valid),
        .i_req   (w_dec_req),
        .o_valid (w_shf_valid),
        .o_res   (w_shf_res)
    );

    // Stage 3: flag generation and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_shf_valid;
        end
        r_result <= w_shf_res.value;
        r_wr     <= w_shf_res.wr;
        r_neg    <= w_shf_res.value[31];
        r_zero   <= (w_shf_res.value == 32'd0);
        r_carry  <= w_shf_res.carry;
    end

    assign o_valid         = r_valid;
    assign o_result_value  = r_result;
    assign o_flags_written = r_wr;
    assign o_neg_flag      = r_neg;
    assign o_zero_flag     = r_zero;
    assign o_carry_out     = r_carry;

    // Every request taken outside reset yields exactly one result strobe
    `AMX_ASSERT_ALWAYS(a_latency, i_clk, i_rst_n, o_valid == ($past(w_accept, 3) && $past(i_rst_n, 3) && $past(i_rst_n, 2) && $past(i_rst_n, 1)), "result strobe does not match request timing")
    // No request is taken in the cycle after reset
    `AMX_ASSERT_IMP(a_busy_after_reset, i_clk, i_rst_n, !$past(i_rst_n), !w_accept, "request accepted straight after reset")

endmodule

/* bench/arm_mov_execute_with_shifter_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// MOV execute result checker
// Watches the request and result ports of the MOV execute unit, works out
// the expected result and flags of every request taken, and compares each
// result strobe field by field against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module arm_mov_execute_with_shifter_checker
    import amx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [1:0]           i_action,
    input  logic [IMM_LOW_W-1:0] i_imm_low12,
    input  logic [3:0]           i_imm_high4,
    input  logic [1:0]           i_shift_kind,
    input  logic [4:0]           i_shift_imm,
    input  logic [31:0]          i_source_value,
    input  logic                 i_carry_in,
    input  logic                 i_set_flags,
    input  logic                 i_valid,
    input  logic [31:0]          i_result_value,
    input  logic                 i_flags_written,
    input  logic                 i_neg_flag,
    input  logic                 i_zero_flag,
    input  logic                 i_carry_out,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [31:0] value;
        logic        wr;
        logic        neg;
        logic        zero;
        logic        carry;
    } t_mov_result;

    // Predicted results, oldest first
    t_mov_result mov_results_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Result and N, Z, C of one MOV in any of its forms
    function automatic t_mov_result predict_mov_result(
        input logic [1:0]  action,
        input logic [11:0] imm_low12,
        input logic [3:0]  imm_high4,
        input logic [1:0]  kind,
        input logic [4:0]  amt,
        input logic [31:0] src,
        input logic        cin,
        input logic        set_flags
    );
        t_mov_result r;
        logic [63:0] twice;
        logic [4:0]  rot;
        int          n;
        r       = '0;
        r.carry = cin;
        n       = amt;
        case (action)
            ACT_ROT_IMM: begin
                // imm8 rotated right by twice the rotate field
                rot     = {imm_low12[11:8], 1'b0};
                twice   = {24'd0, imm_low12[7:0], 24'd0, imm_low12[7:0]};
                twice   = twice >> rot;
                r.value = twice[31:0];
                if (rot != 5'd0)
                    r.carry = r.value[31];
                r.wr = set_flags;
            end
            ACT_IMM16: begin
                // flags never written for the wide immediate
                r.value = {16'd0, imm_high4, imm_low12};
            end
            ACT_SHF_REG: begin
                r.wr = set_flags;
                case (kind)
                    KIND_LSL: begin
                        if (n == 0) begin
                            r.value = src;
                        end else begin
                            r.carry = src[32-n];
                            r.value = src << n;
                        end
                    end
                    KIND_LSR: begin
                        // zero amount encodes a shift by 32
                        if (n == 0) begin
                            r.carry = src[31];
                            r.value = '0;
                        end else begin
                            r.carry = src[n-1];
                            r.value = src >> n;
                        end
                    end
                    KIND_ASR: begin
                        if (n == 0) begin
                            r.carry = src[31];
                            r.value = {32{src[31]}};
                        end else begin
                            r.carry = src[n-1];
                            r.value = $signed(src) >>> n;
                        end
                    end
                    default: begin
                        // zero amount is RRX: rotate by one through C
                        if (n == 0) begin
                            r.carry = src[0];
                            r.value = {cin, src[31:1]};
                        end else begin
                            twice   = {src, src} >> n;
                            r.value = twice[31:0];
                            r.carry = r.value[31];
                        end
                    end
                endcase
            end
            default: begin
                // unused form: zero result, nothing written
                r.value = '0;
            end
        endcase
        r.neg  = r.value[31];
        r.zero = (r.value == 32'd0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Predict on every request taken, compare on every result strobe
    always @(posedge i_clk) begin
        t_mov_result want;
        if (i_rst_n) begin
            if (i_start && !i_busy)
                mov_results_q.push_back(predict_mov_result(i_action, i_imm_low12,
                    i_imm_high4, i_shift_kind, i_shift_imm, i_source_value,
                    i_carry_in, i_set_flags));
            if (i_valid) begin
                if (mov_results_q.size() == 0) begin
                    report_mismatch("unexpected result", i_result_value, 32'd0);
                end else begin
                    want = mov_results_q.pop_front();
                    if (i_result_value !== want.value)
                        report_mismatch("result_value", i_result_value, want.value);
                    if (i_flags_written !== want.wr)
                        report_mismatch("flags_written", {31'd0, i_flags_written},
                                        {31'd0, want.wr});
                    if (i_neg_flag !== want.neg)
                        report_mismatch("neg_flag", {31'd0, i_neg_flag},
                                        {31'd0, want.neg});
                    if (i_zero_flag !== want.zero)
                        report_mismatch("zero_flag", {31'd0, i_zero_flag},
                                        {31'd0, want.zero});
                    if (i_carry_out !== want.carry)
                        report_mismatch("carry_out", {31'd0, i_carry_out},
                                        {31'd0, want.carry});
                end
            end
            o_pending = mov_results_q.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// MOV execute unit testbench
// Drives directed corner cases of all three MOV forms, then a long random
// run with bursts of idle cycles, while the checker predicts and compares
// every result. A watchdog ends the run if traffic stops.
// ---------------------------------------------------------------------------
module tb;
    import amx_pkg::*;

    localparam int NUM_RANDOM    = 500;
    localparam int QUIET_TAIL    = 100;
    localparam int WATCHDOG_MAX  = 200;
    localparam int DRAIN_CYCLES  = 8;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic [1:0]  i_action       = ACT_ROT_IMM;
    logic [11:0] i_imm_low12    = '0;
    logic [3:0]  i_imm_high4    = '0;
    logic [1:0]  i_shift_kind   = KIND_LSL;
    logic [4:0]  i_shift_imm    = '0;
    logic [31:0] i_source_value = '0;
    logic        i_carry_in     = 1'b0;
    logic        i_set_flags    = 1'b0;

    logic        busy;
    logic        o_valid;
    logic [31:0] o_result_value;
    logic        o_flags_written;
    logic        o_neg_flag;
    logic        o_zero_flag;
    logic        o_carry_out;

    int          fail_count;
    int          pending;
    bit          allow_gaps = 1'b1;

    always #5 i_clk = ~i_clk;

    arm_mov_execute_with_shifter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_imm_low12     (i_imm_low12),
        .i_imm_high4     (i_imm_high4),
        .i_shift_kind    (i_shift_kind),
        .i_shift_imm     (i_shift_imm),
        .i_source_value  (i_source_value),
        .i_carry_in      (i_carry_in),
        .i_set_flags     (i_set_flags),
        .o_valid         (o_valid),
        .o_result_value  (o_result_value),
        .o_flags_written (o_flags_written),
        .o_neg_flag      (o_neg_flag),
        .o_zero_flag     (o_zero_flag),
        .o_carry_out     (o_carry_out)
    );

    arm_mov_execute_with_shifter_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_action        (i_action),
        .i_imm_low12     (i_imm_low12),
        .i_imm_high4     (i_imm_high4),
        .i_shift_kind    (i_shift_kind),
        .i_shift_imm     (i_shift_imm),
        .i_source_value  (i_source_value),
        .i_carry_in      (i_carry_in),
        .i_set_flags     (i_set_flags),
        .i_valid         (o_valid),
        .i_result_value  (o_result_value),
        .i_flags_written (o_flags_written),
        .i_neg_flag      (o_neg_flag),
        .i_zero_flag     (o_zero_flag),
        .i_carry_out     (o_carry_out),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // One request: optional idle burst, then hold start until busy is low
    task automatic send_mov(input logic [1:0] act, input logic [11:0] imm12,
                            input logic [3:0] imm4, input logic [1:0] kind,
                            input logic [4:0] amt, input logic [31:0] src,
                            input logic cin, input logic sbit);
        int gap;
        gap = 0;
        if (allow_gaps && $urandom_range(3) == 0)
            gap = $urandom_range(4, 1);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_action       <= act;
        i_imm_low12    <= imm12;
        i_imm_high4    <= imm4;
        i_shift_kind   <= kind;
        i_shift_imm    <= amt;
        i_source_value <= src;
        i_carry_in     <= cin;
        i_set_flags    <= sbit;
        while (busy)
            @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_source();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus and verdict
    initial begin
        logic [1:0] act;
        int         pick;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // rotated immediate: no rotation, rotation into bit 31, max rotation
        send_mov(ACT_ROT_IMM, 12'h0FF, 4'h0, KIND_LSL, 5'd0, 32'h0, 1'b1, 1'b1);
        send_mov(ACT_ROT_IMM, 12'h0FF, 4'h0, KIND_LSL, 5'd0, 32'h0, 1'b0, 1'b1);
        send_mov(ACT_ROT_IMM, 12'h102, 4'h0, KIND_LSL, 5'd0, 32'h0, 1'b0, 1'b1);
        send_mov(ACT_ROT_IMM, 12'hF80, 4'h0, KIND_LSL, 5'd0, 32'h0, 1'b0, 1'b1);
        send_mov(ACT_ROT_IMM, 12'h400, 4'h0, KIND_LSL, 5'd0, 32'h0, 1'b1, 1'b0);
        // wide immediate: S set must not write flags
        send_mov(ACT_IMM16, 12'hFFF, 4'hF, KIND_ROR, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_mov(ACT_IMM16, 12'h000, 4'h0, KIND_LSL, 5'd0, 32'h0, 1'b0, 1'b1);
        // LSL: pass-through, by one, by 31
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_LSL, 5'd0, 32'h8000_0001, 1'b1, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_LSL, 5'd1, 32'h8000_0001, 1'b0, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_LSL, 5'd31, 32'h0000_0003, 1'b0, 1'b1);
        // LSR: zero means 32
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_LSR, 5'd0, 32'h8000_0000, 1'b0, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_LSR, 5'd1, 32'hFFFF_FFFF, 1'b0, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_LSR, 5'd31, 32'hC000_0000, 1'b0, 1'b1);
        // ASR: zero means 32, both signs
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_ASR, 5'd0, 32'h8000_0000, 1'b0, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_ASR, 5'd0, 32'h7FFF_FFFF, 1'b1, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_ASR, 5'd1, 32'h8000_0001, 1'b0, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_ASR, 5'd31, 32'hC000_0000, 1'b0, 1'b1);
        // ROR by zero is RRX, with either carry in
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_ROR, 5'd0, 32'h0000_0001, 1'b0, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_ROR, 5'd0, 32'h0000_0000, 1'b1, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_ROR, 5'd1, 32'h0000_0001, 1'b0, 1'b1);
        send_mov(ACT_SHF_REG, 12'h0, 4'h0, KIND_ROR, 5'd31, 32'h8000_0000, 1'b0, 1'b0);
        // unused form
        send_mov(ACT_NONE, 12'hFFF, 4'hF, KIND_ROR, 5'd31, 32'hFFFF_FFFF, 1'b1, 1'b1);
        send_mov(ACT_NONE, 12'h000, 4'h0, KIND_LSL, 5'd0, 32'h0, 1'b0, 1'b1);

        // random requests, mostly register and rotated-immediate forms
        for (int i = 0; i < NUM_RANDOM; i++) begin
            allow_gaps = (i < NUM_RANDOM - QUIET_TAIL);
            pick = $urandom_range(19);
            if (pick < 6)
                act = ACT_ROT_IMM;
            else if (pick < 9)
                act = ACT_IMM16;
            else if (pick < 19)
                act = ACT_SHF_REG;
            else
                act = ACT_NONE;
            send_mov(act, 12'($urandom), 4'($urandom), 2'($urandom),
                     ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom),
                     pick_source(), 1'($urandom), 1'($urandom));
        end
        @(negedge i_clk);
        start <= 1'b0;

        // drain the pipeline, then allow for any stray strobe
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Watchdog: too many cycles with neither a request taken nor a result
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_MAX) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid)
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: watchdog expired", $realtime);
        $display("tb NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/amx_pkg.sv
sv/amx_decode.sv
sv/amx_shift.sv
sv/arm_mov_execute_with_shifter.sv
bench/arm_mov_execute_with_shifter_checker.sv
bench/tb.sv
